@@ hw/rtl/hcsp_pkg.sv @@
// ----------------------------------------------------------------------------
// hcsp_pkg
// Shared constants, types and helpers for the hex color string parser.
// ----------------------------------------------------------------------------
package hcsp_pkg;

  localparam int unsigned MAX_DIGITS = 12;
  localparam int unsigned CHAR_W     = 8;
  localparam int unsigned NIB_W      = 4;
  localparam int unsigned CNT_W      = 4;
  localparam int unsigned CHAN_W     = 16;
  localparam int unsigned OUT_W      = 3 * CHAN_W;

  localparam logic [CHAR_W-1:0] HASH_CHAR  = 8'h23;
  localparam logic [CHAR_W-1:0] DIGIT_BIT  = 8'h10;
  localparam logic [CHAR_W-1:0] LOWER_BIT  = 8'h20;
  localparam logic [CHAR_W-1:0] ZERO_CHAR  = 8'h30;
  localparam logic [CHAR_W-1:0] A_CHAR     = 8'h61;
  localparam logic [CHAR_W-1:0] A_VALUE    = 8'd10;

  localparam logic [CNT_W-1:0] CNT_MAX  = 4'd12;
  localparam logic [CNT_W-1:0] CNT_OVER = 4'd13;
  localparam logic [CNT_W-1:0] LEN_1    = 4'd3;
  localparam logic [CNT_W-1:0] LEN_2    = 4'd6;
  localparam logic [CNT_W-1:0] LEN_3    = 4'd9;
  localparam logic [CNT_W-1:0] LEN_4    = 4'd12;

  typedef logic [NIB_W-1:0] nib_t;
  typedef nib_t [MAX_DIGITS-1:0] store_t;

  typedef struct packed {
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] red;
  } color_t;

  function automatic nib_t to_nibble(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] v;
    if ((c & DIGIT_BIT) != '0) begin
      v = c - ZERO_CHAR;
    end else begin
      v = (c | LOWER_BIT) - A_CHAR + A_VALUE;
    end
    return v[NIB_W-1:0];
  endfunction

endpackage

@@ hw/rtl/hex_color_string_parser.sv @@
// ----------------------------------------------------------------------------
// hex_color_string_parser
// Parses a hex color string, one character per word, into 16-bit RGB.
// ----------------------------------------------------------------------------
// Takes one character per clock cycle while in_tready is high. A leading '#' is skipped;
// up to twelve digit nibbles are held in flip-flops. The word carrying tlast
// produces one result word, registered, on the cycle after it is accepted.
// Throughput is one character per cycle, limited only by the single output
// register: in_tready drops only while a result is held and not taken.
// tdata: red [15:0], green [31:16], blue [47:32]; tuser: bad_length.
module hex_color_string_parser (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [hcsp_pkg::CHAR_W-1:0] in_tdata,   // [7:0] character
  input  logic                       in_tlast,    // last_char
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [hcsp_pkg::OUT_W-1:0] out_tdata,   // [15:0] red, [31:16] green, [47:32] blue
  output logic                       out_tuser    // [0] bad_length
);

  logic [hcsp_pkg::CNT_W-1:0] count_r, count_nxt;
  logic                       hash_r, hash_nxt;
  hcsp_pkg::store_t           store_r, store_nxt;
  logic                       out_valid_r, out_valid_nxt;
  hcsp_pkg::color_t           color_r, color_nxt;
  logic                       bad_r, bad_nxt;
  logic                       accept;
  logic                       skip_hash;
  hcsp_pkg::nib_t             nib;

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;
  assign skip_hash = (count_r == '0) && !hash_r && (in_tdata == hcsp_pkg::HASH_CHAR);
  assign nib       = hcsp_pkg::to_nibble(in_tdata);

  always_comb begin
    count_nxt = count_r;
    hash_nxt  = hash_r;
    store_nxt = store_r;
    if (skip_hash) begin
      hash_nxt = 1'b1;
    end else if (count_r < hcsp_pkg::CNT_MAX) begin
      for (int i = 0; i < hcsp_pkg::MAX_DIGITS; i++) begin
        if (count_r == hcsp_pkg::CNT_W'(i)) begin
          store_nxt[i] = nib;
        end
      end
      count_nxt = count_r + 1'b1;
    end else begin
      count_nxt = hcsp_pkg::CNT_OVER;
    end
  end

  always_comb begin
    color_nxt = '0;
    bad_nxt   = 1'b0;
    unique case (count_nxt)
      hcsp_pkg::LEN_1: begin
        color_nxt.red   = {4{store_nxt[0]}};
        color_nxt.green = {4{store_nxt[1]}};
        color_nxt.blue  = {4{store_nxt[2]}};
      end
      hcsp_pkg::LEN_2: begin
        color_nxt.red   = {2{store_nxt[0], store_nxt[1]}};
        color_nxt.green = {2{store_nxt[2], store_nxt[3]}};
        color_nxt.blue  = {2{store_nxt[4], store_nxt[5]}};
      end
      hcsp_pkg::LEN_3: begin
        color_nxt.red   = {store_nxt[0], store_nxt[1], store_nxt[2], store_nxt[0]};
        color_nxt.green = {store_nxt[3], store_nxt[4], store_nxt[5], store_nxt[3]};
        color_nxt.blue  = {store_nxt[6], store_nxt[7], store_nxt[8], store_nxt[6]};
      end
      hcsp_pkg::LEN_4: begin
        color_nxt.red   = {store_nxt[0], store_nxt[1], store_nxt[2], store_nxt[3]};
        color_nxt.green = {store_nxt[4], store_nxt[5], store_nxt[6], store_nxt[7]};
        color_nxt.blue  = {store_nxt[8], store_nxt[9], store_nxt[10], store_nxt[11]};
      end
      default: begin
        bad_nxt = 1'b1;
      end
    endcase
  end

  assign out_valid_nxt = (accept && in_tlast) || (out_valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      hash_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        // restart the string after its last character
        count_r <= in_tlast ? '0 : count_nxt;
        hash_r  <= in_tlast ? 1'b0 : hash_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      store_r <= store_nxt;
    end
    if (accept && in_tlast) begin
      color_r <= color_nxt;
      bad_r   <= bad_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = color_r;
  assign out_tuser  = bad_r;

endmodule

@@ hw/rtl/hcsp_checker.sv @@
// ----------------------------------------------------------------------------
// hcsp_checker
// Port-level checks for the hex color string parser, bound to the top level.
// ----------------------------------------------------------------------------
module hcsp_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_tvalid,
  input logic                       in_tready,
  input logic                       in_tlast,
  input logic                       out_tvalid,
  input logic                       out_tready,
  input logic [hcsp_pkg::OUT_W-1:0] out_tdata,
  input logic                       out_tuser
);

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == '0)
    else $error("error result carries color");

  a_from_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !$past(out_tvalid) |-> $past(in_tvalid && in_tready && in_tlast))
    else $error("result without last character");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !in_tlast && (!out_tvalid || out_tready) |=> !out_tvalid)
    else $error("result from a middle character");

endmodule

bind hex_color_string_parser hcsp_checker u_hcsp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
